/* hdl/mcg_pkg.sv */
// Shared types, constants and calendar tables for the month calendar grid block.
package mcg_pkg;

  // Request and cell payloads
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
  } req_t;

  typedef struct packed {
    logic [4:0] day_number;
    logic [2:0] column;
    logic [2:0] row;
    logic       last_cell;
    logic       bad_month;
  } cell_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIVP_MUL,
    S_DIVP_FIX,
    S_DIVY_MUL,
    S_DIVY_FIX,
    S_SUM_A,
    S_SUM_B,
    S_MOD_MUL,
    S_MOD_FIX,
    S_EMIT
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic div_sel_year;
    logic div_mul;
    logic div_fix;
    logic sum_a;
    logic sum_b;
    logic mod_mul;
    logic mod_fix;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic bad;
    logic room;
    logic last;
  } sts_t;

  // Month codes
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Year offset: count whole years before year + 400
  localparam logic [14:0] YEAR_OFFSET = 15'd399;

  // Divide by 25 through a reciprocal, exact for dividends below 4681
  localparam logic [4:0]  DIV25   = 5'd25;
  localparam logic [10:0] RECIP25 = 11'd1311;
  localparam int          SHIFT25 = 15;

  // Divide by 7 through a reciprocal, exact for 15-bit dividends
  localparam logic [2:0]  WEEK_DAYS = 3'd7;
  localparam logic [15:0] RECIP7    = 16'd37450;
  localparam int          SHIFT7    = 18;

  localparam logic [2:0] LAST_COL = 3'd6;

  // Days before the first of the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      MON_JAN: d = 9'd0;
      MON_FEB: d = 9'd31;
      MON_MAR: d = 9'd59;
      MON_APR: d = 9'd90;
      MON_MAY: d = 9'd120;
      MON_JUN: d = 9'd151;
      MON_JUL: d = 9'd181;
      MON_AUG: d = 9'd212;
      MON_SEP: d = 9'd243;
      MON_OCT: d = 9'd273;
      MON_NOV: d = 9'd304;
      MON_DEC: d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Length of the month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      MON_FEB: n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

/* hdl/month_calendar_grid.sv */
// The first cell is loaded into the output register after the weekday arithmetic (after
// only the month check for a bad month), then one cell per cycle while the output flows.
// Each request gives 28, 35 or 42 cells (one for a bad month) after weekday arithmetic on
// the shared divide-by-25 unit and the modulo-7 step; the next request is taken once
// the last cell is loaded. Reset (rst, synchronous) idles the controller, empties output.
module month_calendar_grid (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mcg_pkg::req_t   req_data,
  output logic            cell_valid,
  input  logic            cell_stall,
  output mcg_pkg::cell_t  cell_data
);
  import mcg_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and cell output
  mcg_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .req_data   (req_data),
    .cmd        (cmd),
    .sts        (sts),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data)
  );

endmodule

/* hdl/mcg_ctrl.sv */
// Sequencing state machine for the month calendar grid block.
module mcg_ctrl (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  mcg_pkg::sts_t sts,
  output mcg_pkg::cmd_t cmd
);
  import mcg_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (req_valid) state_next = S_DIVP_MUL;
      S_DIVP_MUL: state_next = sts.bad ? S_EMIT : S_DIVP_FIX;
      S_DIVP_FIX: state_next = S_DIVY_MUL;
      S_DIVY_MUL: state_next = S_DIVY_FIX;
      S_DIVY_FIX: state_next = S_SUM_A;
      S_SUM_A:    state_next = S_SUM_B;
      S_SUM_B:    state_next = S_MOD_MUL;
      S_MOD_MUL:  state_next = S_MOD_FIX;
      S_MOD_FIX:  state_next = S_EMIT;
      S_EMIT:     if (sts.room && sts.last) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_DIVP_MUL: cmd.div_mul = 1'b1;
      S_DIVP_FIX: cmd.div_fix = 1'b1;
      S_DIVY_MUL: begin
        cmd.div_sel_year = 1'b1;
        cmd.div_mul      = 1'b1;
      end
      S_DIVY_FIX: begin
        cmd.div_sel_year = 1'b1;
        cmd.div_fix      = 1'b1;
      end
      S_SUM_A:   cmd.sum_a   = 1'b1;
      S_SUM_B:   cmd.sum_b   = 1'b1;
      S_MOD_MUL: cmd.mod_mul = 1'b1;
      S_MOD_FIX: cmd.mod_fix = 1'b1;
      S_EMIT:    cmd.emit    = sts.room;
      default:   cmd = '0;
    endcase
  end

endmodule

/* hdl/mcg_dpath.sv */
// Datapath: weekday arithmetic, leap test, cell counters and the cell output register.
module mcg_dpath (
  input  logic          clk,
  input  logic          rst,
  input  mcg_pkg::req_t req_data,
  input  mcg_pkg::cmd_t cmd,
  output mcg_pkg::sts_t sts,
  output logic          cell_valid,
  input  logic          cell_stall,
  output mcg_pkg::cell_t cell_data
);
  import mcg_pkg::*;

  // Request registers
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic        bad_r;

  // Divide-by-25 unit and its results
  logic [23:0] div_prod;
  logic [12:0] div_x;
  logic [8:0]  div_q;
  logic [12:0] div_rem;
  logic [7:0]  div_q_fix;
  logic [12:0] div_rem_fix;
  logic [7:0]  q100;
  logic [7:0]  yq;
  logic        yrem_zero;

  // Day count and weekday
  logic [14:0] p;
  logic [14:0] acc;
  logic [30:0] mod_prod;
  logic [12:0] q7;
  logic [14:0] r7;
  logic [2:0]  start_r;
  logic        leap;
  logic [4:0]  len;

  // Cell walk
  logic [5:0] k;
  logic [2:0] col;
  logic [2:0] row;
  logic [6:0] end_k;
  logic       in_month;
  logic [5:0] day_full;
  logic       last;

  assign p = {1'b0, year_r} + YEAR_OFFSET;

  // Dividend select: p/4 for the day count, year/4 for the leap test
  assign div_x = cmd.div_sel_year ? {1'b0, year_r[13:2]} : p[14:2];

  always_comb begin
    div_q   = div_prod[23:SHIFT25];
    div_rem = div_x - 13'(13'(div_q) * 13'(DIV25));
    if (div_rem >= 13'(DIV25)) begin
      div_q_fix   = 8'(div_q + 9'd1);
      div_rem_fix = div_rem - 13'(DIV25);
    end else begin
      div_q_fix   = div_q[7:0];
      div_rem_fix = div_rem;
    end
  end

  // y%100==0 iff (y>>2)%25==0 with y%4==0; y/100 equals (y>>2)/25
  assign leap = (year_r[1:0] == 2'd0) && (!yrem_zero || (yq[1:0] == 2'd0));
  assign len  = month_len(month_r, leap);

  // Remainder by 7 with one correction step
  always_comb begin
    q7 = mod_prod[30:SHIFT7];
    r7 = acc - 15'(15'(q7) * 15'(WEEK_DAYS));
    if (r7 >= 15'(WEEK_DAYS)) begin
      r7 = r7 - 15'(WEEK_DAYS);
    end
  end

  // Arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      year_r  <= req_data.year;
      month_r <= req_data.month;
      bad_r   <= (req_data.month < MON_JAN) || (req_data.month > MON_DEC);
    end
    if (cmd.div_mul) begin
      div_prod <= 24'(div_x) * 24'(RECIP25);
    end
    if (cmd.div_fix) begin
      if (cmd.div_sel_year) begin
        yq        <= div_q_fix;
        yrem_zero <= (div_rem_fix == 13'd0);
      end else begin
        q100 <= div_q_fix;
      end
    end
    if (cmd.sum_a) begin
      acc <= p + 15'(p[14:2]) + 15'(cum_days(month_r)) + 15'd1;
    end
    if (cmd.sum_b) begin
      acc <= acc - 15'(q100) + 15'(q100[7:2]) + 15'(leap && (month_r > MON_FEB));
    end
    if (cmd.mod_mul) begin
      mod_prod <= 31'(acc) * 31'(RECIP7);
    end
    if (cmd.mod_fix) begin
      start_r <= r7[2:0];
    end
  end

  // Cell contents for the current position
  assign end_k    = 7'(start_r) + 7'(len);
  assign in_month = (k >= 6'(start_r)) && (7'(k) < end_k);
  assign day_full = k - 6'(start_r) + 6'd1;
  assign last     = bad_r || ((col == LAST_COL) && (7'(k) + 7'd1 >= end_k));

  // Position counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k   <= '0;
      col <= '0;
      row <= '0;
    end else if (cmd.emit) begin
      k <= k + 6'd1;
      if (col == LAST_COL) begin
        col <= '0;
        row <= row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (cmd.emit) begin
      cell_valid <= 1'b1;
    end else if (!cell_stall) begin
      cell_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (bad_r) begin
        cell_data <= '{day_number: 5'd0, column: 3'd0, row: 3'd0,
                       last_cell: 1'b1, bad_month: 1'b1};
      end else begin
        cell_data <= '{day_number: in_month ? day_full[4:0] : 5'd0,
                       column: col, row: row, last_cell: last, bad_month: 1'b0};
      end
    end
  end

  assign sts.bad  = bad_r;
  assign sts.room = !cell_valid || !cell_stall;
  assign sts.last = last;

endmodule

/* bench/tb_month_calendar_grid.sv */
// Self-checking testbench for the month calendar grid block: random and directed requests.
module tb_month_calendar_grid;
  timeunit 1ns;
  timeprecision 1ps;

  import mcg_pkg::*;

  // Months outside the calendar, used to exercise the error cell
  localparam logic [3:0] MON_NONE = 4'd0;
  localparam logic [3:0] MON_TOP  = 4'd15;

  localparam int RANDOM_REQS = 300;
  localparam int CALM_TAIL   = 40;      // final requests run with no idling
  localparam int HOLD_AT     = 60;      // requests taken before the long output hold
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 40;      // cycles allowed after the last cell
  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    req_t req;
    bit   drain_first;                  // wait for every grid cell before offering
  } job_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req_data = '0;
  logic  cell_valid;
  logic  cell_stall = 1'b0;
  cell_t cell_data;

  job_t  job_q[$];
  cell_t grid_q[$];

  logic        req_taken  = 1'b0;
  logic        calm       = 1'b0;
  int          reqs_taken = 0;
  int          send_gap   = 0;
  int          recv_gap   = 0;
  int          phase_left = 0;
  logic        quiet      = 1'b0;
  int          hold_left  = 0;
  logic        hold_done  = 1'b0;
  int          faults     = 0;
  int unsigned cycles     = 0;

  month_calendar_grid dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_data   (req_data),
    .cell_valid (cell_valid),
    .cell_stall (cell_stall),
    .cell_data  (cell_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned y, input logic [3:0] m);
    case (m)
      MON_FEB: return leap_year(y) ? 29 : 28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  // Queue up every cell of the grid for one request
  function automatic void predict_grid(input req_t r);
    int unsigned y, p, days, first_col, len, n_cells, d;
    cell_t c;
    y = r.year;
    if (r.month < MON_JAN || r.month > MON_DEC) begin
      c = '0;
      c.last_cell = 1'b1;
      c.bad_month = 1'b1;
      grid_q.push_back(c);
      return;
    end
    // count from year + 400, same weekdays and leap pattern
    p = y + 399;
    days = p * 365 + p / 4 - p / 100 + p / 400 + 1;
    for (int k = 1; k < r.month; k++) begin
      days += days_in_month(y, 4'(k));
    end
    first_col = days % 7;
    len = days_in_month(y, r.month);
    n_cells = ((first_col + len + 6) / 7) * 7;
    for (int unsigned k = 0; k < n_cells; k++) begin
      d = (k >= first_col && k < first_col + len) ? k - first_col + 1 : 0;
      c.day_number = 5'(d);
      c.column     = 3'(k % 7);
      c.row        = 3'(k / 7);
      c.last_cell  = (k + 1 == n_cells);
      c.bad_month  = 1'b0;
      grid_q.push_back(c);
    end
  endfunction

  task automatic add_job(input int unsigned y, input logic [3:0] m, input bit drain);
    job_t j;
    j.req.year    = 14'(y);
    j.req.month   = m;
    j.drain_first = drain;
    job_q.push_back(j);
  endtask

  // Request driver: holds a stalled request, idles in bursts, drains on demand
  always @(negedge clk) begin : drive_req
    calm <= (job_q.size() <= CALM_TAIL);
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_taken) begin
      // still waiting for the block to take it
    end else if (send_gap > 0) begin
      req_valid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (job_q.size() == 0) begin
      req_valid <= 1'b0;
    end else if (job_q[0].drain_first && grid_q.size() != 0) begin
      req_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 2) == 0) begin
      req_valid <= 1'b0;
      send_gap  <= $urandom_range(0, 6);
    end else begin
      req_data  <= job_q[0].req;
      req_valid <= 1'b1;
      job_q.pop_front();
    end
  end

  // Long output hold once enough requests are in, so the block backs up
  always @(negedge clk) begin : long_hold_timer
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reqs_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Cell receiver: random stall bursts, with quiet stretches in between
  always @(negedge clk) begin : drive_cell_stall
    if (phase_left == 0) begin
      quiet      <= ($urandom_range(0, 3) == 0);
      phase_left <= $urandom_range(50, 200);
    end else begin
      phase_left <= phase_left - 1;
    end
    if (rst) begin
      cell_stall <= 1'b0;
    end else if (hold_left > 0) begin
      cell_stall <= 1'b1;
    end else if (recv_gap > 0) begin
      cell_stall <= 1'b1;
      recv_gap   <= recv_gap - 1;
    end else if (!calm && !quiet && $urandom_range(0, 4) == 0) begin
      cell_stall <= 1'b1;
      recv_gap   <= $urandom_range(0, 6);
    end else begin
      cell_stall <= 1'b0;
    end
  end

  // Predict on each taken request, check each taken cell, watch the clock
  always @(posedge clk) begin : check_cells
    cell_t want;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d cells outstanding", cycles, grid_q.size());
      $display("*** FAILED ***");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_valid && !req_stall;
      if (req_valid && !req_stall) begin
        predict_grid(req_data);
        reqs_taken <= reqs_taken + 1;
      end
      if (cell_valid && !cell_stall) begin
        if (grid_q.size() == 0) begin
          if (faults < MAX_SHOWN) begin
            $display("unexpected cell: day %0d col %0d row %0d last %0b bad %0b",
                     cell_data.day_number, cell_data.column, cell_data.row,
                     cell_data.last_cell, cell_data.bad_month);
          end
          faults++;
        end else begin
          want = grid_q.pop_front();
          if (cell_data.day_number !== want.day_number ||
              cell_data.column     !== want.column     ||
              cell_data.row        !== want.row        ||
              cell_data.last_cell  !== want.last_cell  ||
              cell_data.bad_month  !== want.bad_month) begin
            if (faults < MAX_SHOWN) begin
              $display("cell mismatch: want day %0d col %0d row %0d last %0b bad %0b",
                       want.day_number, want.column, want.row,
                       want.last_cell, want.bad_month);
              $display("               got  day %0d col %0d row %0d last %0b bad %0b",
                       cell_data.day_number, cell_data.column, cell_data.row,
                       cell_data.last_cell, cell_data.bad_month);
            end
            faults++;
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned y;
    logic [3:0]  m;
    rst = 1'b1;

    // error cells, including the field extremes of the year
    add_job(0,     MON_NONE,        1'b0);
    add_job(16383, 4'(MON_DEC + 1), 1'b0);
    add_job(2024,  4'(MON_DEC + 2), 1'b0);
    add_job(16383, MON_TOP,         1'b0);
    // first month of the era, last of the intended range, year zero, top of the field
    add_job(1,     MON_JAN, 1'b0);
    add_job(9999,  MON_DEC, 1'b0);
    add_job(0,     MON_FEB, 1'b0);
    add_job(16383, MON_JUN, 1'b0);
    // leap rule corners, and a four-row February
    add_job(2000,  MON_FEB, 1'b0);
    add_job(1900,  MON_FEB, 1'b0);
    add_job(2015,  MON_FEB, 1'b0);
    // a full year: five- and six-row months among them
    for (int k = MON_JAN; k <= MON_DEC; k++) begin
      add_job(2021, 4'(k), 1'b0);
    end

    // random part; drain before it starts and once midway
    for (int i = 0; i < RANDOM_REQS; i++) begin
      case ($urandom_range(0, 9))
        0, 1:    y = $urandom_range(0, 16383);
        2:       y = $urandom_range(0, 163) * 100;
        default: y = $urandom_range(1, 9999);
      endcase
      case ($urandom_range(0, 9))
        0:       m = 4'($urandom_range(0, 15));
        1:       m = MON_FEB;
        default: m = 4'($urandom_range(MON_JAN, MON_DEC));
      endcase
      add_job(y, m, (i == 0) || (i == RANDOM_REQS / 2));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || req_valid) @(posedge clk);
    while (grid_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (faults == 0 && grid_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mcg_pkg.sv
hdl/mcg_ctrl.sv
hdl/mcg_dpath.sv
hdl/month_calendar_grid.sv
bench/tb_month_calendar_grid.sv
